### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the integrity chain monitor RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on the rising clock, off while reset is low.
`define FIC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("fic assertion failed");

// Antecedent in one cycle, consequent in the next.
`define FIC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fic assertion failed");

`endif

### sv/fic_pkg.sv
// ----------------------------------------------------------------------------
// fic_pkg
// Types, codes and constants of the integrity chain monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package fic_pkg;

  typedef enum logic [1:0] {
    FUNC_START  = 2'd0,
    FUNC_UPDATE = 2'd1,
    FUNC_TAMPER = 2'd2,
    FUNC_CHECK  = 2'd3
  } func_e_t;

  typedef enum logic [1:0] {
    MODE_INVALID = 2'd0,
    MODE_ACTIVE  = 2'd1,
    MODE_CORRUPT = 2'd2
  } mode_e_t;

  typedef enum logic [2:0] {
    CHK_OK       = 3'd0,
    CHK_CORRUPT  = 3'd1,
    CHK_INVALID  = 3'd2,
    CHK_VERSION  = 3'd3,
    CHK_OVERFLOW = 3'd4,
    CHK_BROKEN   = 3'd5,
    CHK_TAG      = 3'd6
  } chk_e_t;

  localparam logic [31:0] SEED_BASE    = 32'h2024_0703;
  localparam logic [63:0] FNV_BASIS    = 64'hCBF2_9CE4_8422_2325;
  localparam logic [63:0] POISON_WORD  = 64'hDEAD_BEEF_CAFE_BABE;
  // byte i = (i * 0x5A) mod 256
  localparam logic [63:0] TAG_SCRAMBLE = 64'h761C_C268_0EB4_5A00;
  // byte i = 0xFF - i
  localparam logic [63:0] TAG_POISON   = 64'hF8F9_FAFB_FCFD_FEFF;

  typedef struct packed {
    func_e_t     func;
    logic [7:0]  event_code;
    logic [55:0] event_payload;
    logic [7:0]  violation_code;
  } item_t;

  typedef struct packed {
    logic        status;
    chk_e_t      check_code;
    logic [63:0] chain_value;
    logic [63:0] step_total;
    logic [63:0] tag_value;
  } result_t;

  // x * 0x100000001B3 mod 2^64 as shift-add: 2^40 + 256 + 128 + 32 + 16 + 2 + 1
  function automatic logic [63:0] fnv_mul(input logic [63:0] x);
    logic [63:0] a;
    logic [63:0] b;
    logic [63:0] c;
    a = (x << 40) + (x << 8);
    b = (x << 7) + (x << 5);
    c = (x << 4) + (x << 1) + x;
    return a + b + c;
  endfunction

  function automatic chk_e_t run_check(input mode_e_t     mode,
                                       input logic [15:0] seed_hi,
                                       input logic [63:0] cnt,
                                       input logic [63:0] chain,
                                       input logic [63:0] tag);
    chk_e_t res;
    if (mode != MODE_ACTIVE) begin
      res = (mode == MODE_CORRUPT) ? CHK_CORRUPT : CHK_INVALID;
    end else if (seed_hi != SEED_BASE[31:16]) begin
      res = CHK_VERSION;
    end else if (&cnt) begin
      res = CHK_OVERFLOW;
    end else if ((|cnt) && !(|chain)) begin
      res = CHK_BROKEN;
    end else if (!(|tag)) begin
      res = CHK_TAG;
    end else begin
      res = CHK_OK;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### sv/fnv1a_integrity_chain_monitor.sv
// ----------------------------------------------------------------------------
// fnv1a_integrity_chain_monitor
// FNV-1a style 64-bit integrity chain over an event stream, with start,
// update, tamper and check-only transactions and a periodic tag refresh.
// ----------------------------------------------------------------------------
// Pipeline: an accepted transaction is held in the input register, then the
//   state update and the result register take it together once the result
//   register is free; out_tvalid is high while the result register holds it.
// Throughput: 1 transaction per cycle unless out_tready stalls; the state
//   update loop (xor plus shift-add multiply by FNV prime) is combinational.
// Reset: synchronous, active low; clears the state to uninitialized with
//   zero chain, count and tag, machine_id to zero, and both stages to empty.
// ----------------------------------------------------------------------------
`default_nettype none

module fnv1a_integrity_chain_monitor
  import fic_pkg::*;
#(
  parameter int unsigned TAG_REFRESH_PERIOD = 256
)
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // configuration: machine_id
  input  wire logic         cfg_we,
  input  wire logic [63:0]  cfg_wdata,
  // input channel
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_tdata: event_code[7:0], event_payload[63:8], violation_code[71:64]
  input  wire logic [71:0]  in_tdata,
  // in_tuser: func[1:0]
  input  wire logic [1:0]   in_tuser,
  // result channel
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_tdata: check_code[2:0], chain_value[66:3], step_total[130:67],
  //            tag_value[194:131], zero pad[199:195]
  output logic [199:0]      out_tdata,
  // out_tuser: status[0]
  output logic [0:0]        out_tuser
);

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    adv;
  result_t result;
  result_t out_result;

  // unpack input transaction
  assign in_item.func           = func_e_t'(in_tuser);
  assign in_item.event_code     = in_tdata[7:0];
  assign in_item.event_payload  = in_tdata[63:8];
  assign in_item.violation_code = in_tdata[71:64];

  fic_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .adv        (adv),
    .item_valid (item_valid),
    .item       (item)
  );

  // state advances exactly when a held item moves into the result register
  fic_core #(
    .TAG_REFRESH_PERIOD (TAG_REFRESH_PERIOD)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .fire      (item_valid && adv),
    .item      (item),
    .result    (result)
  );

  fic_out_stage u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_tready  (out_tready),
    .load_valid  (item_valid),
    .load_result (result),
    .adv         (adv),
    .out_tvalid  (out_tvalid),
    .out_result  (out_result)
  );

  // pack result transaction
  assign out_tdata = {5'b0,
                      out_result.tag_value,
                      out_result.step_total,
                      out_result.chain_value,
                      out_result.check_code};
  assign out_tuser = out_result.status;

endmodule

`default_nettype wire

### sv/fic_in_stage.sv
// ----------------------------------------------------------------------------
// fic_in_stage
// Input register: captures one transaction, holds it while the core stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module fic_in_stage
  import fic_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_tvalid,
  output logic       in_tready,
  input  wire item_t in_item,
  input  wire logic  adv,
  output logic       item_valid,
  output item_t      item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_tready = !valid_r || adv;
  assign valid_nxt = in_tready ? in_tvalid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

`default_nettype wire

### sv/fic_core.sv
// ----------------------------------------------------------------------------
// fic_core
// Monitor state and its combinational update for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fic_core
  import fic_pkg::*;
#(
  parameter int unsigned TAG_REFRESH_PERIOD = 256
)
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata,
  input  wire logic        fire,
  input  wire item_t       item,
  output result_t          result
);

  localparam int unsigned PW = $clog2(TAG_REFRESH_PERIOD);
  localparam logic [PW-1:0] PHASE_LAST = PW'(TAG_REFRESH_PERIOD - 1);
  localparam logic [63:0] POISON_MOD = POISON_WORD % 64'(TAG_REFRESH_PERIOD);
  localparam logic [PW-1:0] POISON_PHASE = PW'(POISON_MOD);

  logic [63:0]   machine_id_r;
  mode_e_t       mode_r,    mode_nxt;
  logic [15:0]   seed_hi_r, seed_hi_nxt;
  logic [63:0]   count_r,   count_nxt;
  logic [63:0]   chain_r,   chain_nxt;
  logic [63:0]   tag_r,     tag_nxt;
  logic [PW-1:0] phase_r,   phase_nxt;   // count mod refresh period
  chk_e_t        check_r,   check_nxt;   // check of the current state
  logic          status;
  logic          refuse;
  logic [31:0]   seed_full;
  logic [63:0]   mixed;

  assign seed_full = SEED_BASE ^ machine_id_r[63:32];
  assign mixed     = fnv_mul(chain_r ^ {item.event_code, item.event_payload});

  always_comb begin
    mode_nxt    = mode_r;
    seed_hi_nxt = seed_hi_r;
    count_nxt   = count_r;
    chain_nxt   = chain_r;
    tag_nxt     = tag_r;
    phase_nxt   = phase_r;
    status      = 1'b0;
    case (item.func)
      FUNC_START: begin
        mode_nxt    = MODE_ACTIVE;
        seed_hi_nxt = seed_full[31:16];
        count_nxt   = '0;
        chain_nxt   = FNV_BASIS;
        tag_nxt     = machine_id_r ^ {32'b0, seed_full};
        phase_nxt   = '0;
      end
      FUNC_UPDATE: begin
        if (check_r != CHK_OK) begin
          mode_nxt = MODE_CORRUPT;
          status   = 1'b1;
        end else begin
          count_nxt = count_r + 64'd1;
          chain_nxt = mixed;
          if (phase_r == PHASE_LAST) begin
            phase_nxt = '0;
            tag_nxt   = mixed ^ count_nxt ^ TAG_SCRAMBLE;
          end else begin
            phase_nxt = phase_r + PW'(1);
          end
        end
      end
      FUNC_TAMPER: begin
        mode_nxt  = MODE_CORRUPT;
        chain_nxt = (chain_r ^ POISON_WORD) + {56'b0, item.violation_code};
        tag_nxt   = tag_r ^ TAG_POISON;
        count_nxt = POISON_WORD;
        phase_nxt = POISON_PHASE;
      end
      FUNC_CHECK: begin
      end
      default: begin
      end
    endcase
    check_nxt = run_check(mode_nxt, seed_hi_nxt, count_nxt, chain_nxt, tag_nxt);
  end

  assign refuse = fire && (item.func == FUNC_UPDATE) && (check_r != CHK_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      machine_id_r <= '0;
    end else if (cfg_we) begin
      machine_id_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_INVALID;
      seed_hi_r <= '0;
      count_r   <= '0;
      chain_r   <= '0;
      tag_r     <= '0;
      phase_r   <= '0;
      check_r   <= CHK_INVALID;
    end else if (fire) begin
      mode_r    <= mode_nxt;
      seed_hi_r <= seed_hi_nxt;
      count_r   <= count_nxt;
      chain_r   <= chain_nxt;
      tag_r     <= tag_nxt;
      phase_r   <= phase_nxt;
      check_r   <= check_nxt;
    end
  end

  assign result.status      = status;
  assign result.check_code  = check_nxt;
  assign result.chain_value = chain_nxt;
  assign result.step_total  = count_nxt;
  assign result.tag_value   = tag_nxt;

  `FIC_ASSERT(a_ok_is_active, clk, rst_n, (check_r == CHK_OK) |-> (mode_r == MODE_ACTIVE))
  `FIC_ASSERT_NEXT(a_refuse_holds, clk, rst_n, refuse, (mode_r == MODE_CORRUPT) && $stable(chain_r) && $stable(count_r))
  `FIC_ASSERT(a_phase_range, clk, rst_n, phase_r <= PHASE_LAST)

endmodule

`default_nettype wire

### sv/fic_out_stage.sv
// ----------------------------------------------------------------------------
// fic_out_stage
// Result register: holds a result until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module fic_out_stage
  import fic_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    out_tready,
  input  wire logic    load_valid,
  input  wire result_t load_result,
  output logic         adv,
  output logic         out_tvalid,
  output result_t      out_result
);

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  // register is free when empty or being drained this cycle
  assign adv       = !valid_r || out_tready;
  assign valid_nxt = adv ? load_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load_valid) begin
      result_r <= load_result;
    end
  end

  assign out_tvalid = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

### sim/tb_fnv1a_integrity_chain_monitor.sv
// ----------------------------------------------------------------------------
// tb_fnv1a_integrity_chain_monitor
// Self-checking bench for the FNV-1a integrity chain monitor. A behavioral
// copy of the monitor state predicts every result transaction; a sink
// process compares each one field by field, in order. Directed tests cover
// reset state, field extremes, machine_id corner values and a forced broken
// chain; random traffic then runs start/update sequences with noise, long
// enough runs to hit the tag refresh, and random idling on both sides.
// ----------------------------------------------------------------------------

module tb_fnv1a_integrity_chain_monitor
  import fic_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TAG_REFRESH = 256;
  localparam logic [63:0] MIX_PRIME   = 64'h0000_0100_0000_01B3;
  localparam int          CYCLE_LIMIT = 300_000;
  // cycles to let the two-stage pipeline empty before a config write / end
  localparam int          SETTLE_CYCLES = 6;
  localparam int          RANDOM_PHASES = 6;
  localparam int          PHASE_ITEMS   = 70;
  localparam int          LONG_RUN      = 260;
  localparam int          LOG_LIMIT     = 200;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [63:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  // in_tdata: event_code[7:0], event_payload[63:8], violation_code[71:64]
  logic [71:0]  in_tdata;
  // in_tuser: func[1:0]
  logic [1:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  // out_tdata: check_code[2:0], chain_value[66:3], step_total[130:67],
  //            tag_value[194:131], zero pad[199:195]
  logic [199:0] out_tdata;
  // out_tuser: status[0]
  logic [0:0]   out_tuser;

  fnv1a_integrity_chain_monitor #(
    .TAG_REFRESH_PERIOD(TAG_REFRESH)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // --------------------------------------------------------------------------
  // Monitor state as the bench sees it, advanced once per accepted input
  // transaction. Expected results wait in chain_results_q until the sink
  // pops them.
  // --------------------------------------------------------------------------
  mode_e_t     mdl_mode;
  logic [31:0] mdl_seed;
  logic [63:0] mdl_count;
  logic [63:0] mdl_chain;
  logic [63:0] mdl_tag;
  logic [63:0] mdl_machine_id;

  result_t     chain_results_q[$];
  int          mismatches;
  int          items_sent;
  int          cycle_count;
  int          in_calm;
  int          out_calm;

  // Validity check of the monitor state, first failing condition wins.
  function automatic chk_e_t state_verdict();
    if (mdl_mode != MODE_ACTIVE) begin
      return (mdl_mode == MODE_CORRUPT) ? CHK_CORRUPT : CHK_INVALID;
    end
    if (mdl_seed[31:16] != SEED_BASE[31:16]) return CHK_VERSION;
    if (mdl_count == '1) return CHK_OVERFLOW;
    if (mdl_count != '0 && mdl_chain == '0) return CHK_BROKEN;
    if (mdl_tag == '0) return CHK_TAG;
    return CHK_OK;
  endfunction

  // Apply one input transaction to the state and form its result.
  function automatic result_t fold_event(item_t it);
    result_t r;
    logic    refused;
    refused = 1'b0;
    case (it.func)
      FUNC_START: begin
        // full reinitialization from whatever mode we were in
        mdl_mode  = MODE_ACTIVE;
        mdl_seed  = SEED_BASE ^ mdl_machine_id[63:32];
        mdl_count = '0;
        mdl_chain = FNV_BASIS;
        mdl_tag   = mdl_machine_id ^ {32'h0, mdl_seed};
      end
      FUNC_UPDATE: begin
        if (state_verdict() != CHK_OK) begin
          // refused: only the mode moves
          mdl_mode = MODE_CORRUPT;
          refused  = 1'b1;
        end else begin
          mdl_count = mdl_count + 64'd1;
          mdl_chain = (mdl_chain ^ {it.event_code, it.event_payload}) * MIX_PRIME;
          if (mdl_count % TAG_REFRESH == 0) begin
            mdl_tag = mdl_chain ^ mdl_count ^ TAG_SCRAMBLE;
          end
        end
      end
      FUNC_TAMPER: begin
        mdl_mode  = MODE_CORRUPT;
        mdl_chain = (mdl_chain ^ POISON_WORD) + {56'h0, it.violation_code};
        mdl_tag   = mdl_tag ^ TAG_POISON;
        mdl_count = POISON_WORD;
      end
      default: ;  // check only
    endcase
    r.status      = refused;
    r.check_code  = state_verdict();
    r.chain_value = mdl_chain;
    r.step_total  = mdl_count;
    r.tag_value   = mdl_tag;
    return r;
  endfunction

  function automatic item_t pack_item(func_e_t f, logic [7:0] code,
                                      logic [55:0] payload, logic [7:0] viol);
    item_t it;
    it.func           = f;
    it.event_code     = code;
    it.event_payload  = payload;
    it.violation_code = viol;
    return it;
  endfunction

  function automatic item_t random_item(func_e_t f);
    logic [63:0] wide;
    logic [55:0] payload;
    wide = {$urandom(), $urandom()};
    case ($urandom_range(0, 15))
      0:       payload = '0;
      1:       payload = '1;
      default: payload = wide[55:0];
    endcase
    return pack_item(f, 8'($urandom_range(0, 255)), payload,
                     8'($urandom_range(0, 255)));
  endfunction

  // Idle cycles before the next transaction; now and then a calm stretch.
  function automatic int draw_idle(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void compare_field(string name, logic [63:0] want,
                                        logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      // log only the first ones
      if (mismatches <= LOG_LIMIT) begin
        $display("%0t ns: %s mismatch, expected %h, actual %h",
                 $time, name, want, got);
      end
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input side. in_tvalid stays high after an accepted transaction when the
  // next one follows with no gap; whoever waits next drops it first.
  // --------------------------------------------------------------------------
  task automatic send_item(item_t it);
    int gap;
    gap = draw_idle(in_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {it.violation_code, it.event_payload, it.event_code};
    in_tuser  <= it.func;
    do @(posedge clk); while (in_tready !== 1'b1);
    chain_results_q.push_back(fold_event(it));
    items_sent++;
  endtask

  // Stop sending and let every outstanding result drain.
  task automatic settle_pipeline();
    in_tvalid <= 1'b0;
    while (chain_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_machine_id(logic [63:0] id);
    settle_pipeline();
    cfg_we    <= 1'b1;
    cfg_wdata <= id;
    @(posedge clk);
    cfg_we    <= 1'b0;
    mdl_machine_id = id;
  endtask

  // Start, then len transactions: updates, or with noise_pct percent chance
  // a check, tamper, restart or a fully random transaction.
  task automatic run_sequence(int len, int noise_pct);
    int pick;
    send_item(random_item(FUNC_START));
    repeat (len) begin
      if ($urandom_range(0, 99) >= noise_pct) begin
        send_item(random_item(FUNC_UPDATE));
      end else begin
        pick = $urandom_range(0, 3);
        case (pick)
          0:       send_item(random_item(FUNC_CHECK));
          1:       send_item(random_item(FUNC_TAMPER));
          2:       send_item(random_item(FUNC_START));
          default: send_item(random_item(func_e_t'($urandom_range(0, 3))));
        endcase
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Uninitialized state: check reports invalid, update is refused and
  // corrupts, then a start with the reset machine_id recovers.
  task automatic test_reset_state();
    send_item(random_item(FUNC_CHECK));
    send_item(random_item(FUNC_UPDATE));
    send_item(random_item(FUNC_CHECK));
    send_item(random_item(FUNC_START));
  endtask

  // Field extremes on update and tamper, tamper from active and corrupted
  // modes, start after tamper.
  task automatic test_field_extremes();
    send_item(pack_item(FUNC_UPDATE, 8'h00, '0, 8'h00));
    send_item(pack_item(FUNC_UPDATE, 8'hFF, '1, 8'hFF));
    send_item(pack_item(FUNC_CHECK,  8'hFF, '1, 8'hFF));
    send_item(pack_item(FUNC_TAMPER, 8'h00, '0, 8'h00));
    send_item(random_item(FUNC_UPDATE));
    send_item(random_item(FUNC_START));
    send_item(pack_item(FUNC_TAMPER, 8'hFF, '1, 8'hFF));
    send_item(random_item(FUNC_TAMPER));
    send_item(random_item(FUNC_CHECK));
    send_item(random_item(FUNC_START));
  endtask

  // All-ones id breaks the seed version; the seed base as id yields an
  // all-zero tag. Both make the following update fail.
  task automatic test_machine_id_extremes();
    load_machine_id('1);
    send_item(random_item(FUNC_START));
    send_item(random_item(FUNC_UPDATE));
    load_machine_id({32'h0, SEED_BASE});
    send_item(random_item(FUNC_START));
    send_item(random_item(FUNC_UPDATE));
    load_machine_id('0);
    send_item(random_item(FUNC_START));
  endtask

  // Mixing in the current chain value drives the chain to zero with a
  // nonzero count; the next update is refused.
  task automatic test_chain_broken();
    send_item(pack_item(FUNC_UPDATE, mdl_chain[63:56], mdl_chain[55:0], 8'h00));
    send_item(random_item(FUNC_UPDATE));
  endtask

  // Per phase a fresh machine_id. Most ids keep the top 16 bits clear so
  // starts succeed; every third phase uses a fully random id. Phases 0 and
  // 4 open with a clean run long enough to cross a tag refresh.
  task automatic test_random_traffic();
    logic [63:0] id;
    int          phase_start;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      id = {$urandom(), $urandom()};
      if (p % 3 != 2) id[63:48] = '0;
      load_machine_id(id);
      phase_start = items_sent;
      if (p % 4 == 0) run_sequence(LONG_RUN, 0);
      while (items_sent - phase_start < PHASE_ITEMS) begin
        run_sequence($urandom_range(4, 40), 20);
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: random back-pressure, one comparison per transaction.
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int      gap;
    result_t want;
    wait (rst_n === 1'b1);
    forever begin
      gap = draw_idle(out_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (out_tvalid !== 1'b1);
      if (chain_results_q.size() == 0) begin
        mismatches++;
        $display("%0t ns: unexpected result, expected none, actual %h / %h",
                 $time, out_tuser, out_tdata);
      end else begin
        want = chain_results_q.pop_front();
        compare_field("status",      64'(want.status),     64'(out_tuser[0]));
        compare_field("check_code",  64'(want.check_code), 64'(out_tdata[2:0]));
        compare_field("chain_value", want.chain_value,     out_tdata[66:3]);
        compare_field("step_total",  want.step_total,      out_tdata[130:67]);
        compare_field("tag_value",   want.tag_value,       out_tdata[194:131]);
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin : main_sequence
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = FUNC_CHECK;
    out_tready = 1'b0;
    mismatches = 0;
    items_sent = 0;
    in_calm    = 0;
    out_calm   = 0;
    // reset values of the monitor state
    mdl_mode       = MODE_INVALID;
    mdl_seed       = '0;
    mdl_count      = '0;
    mdl_chain      = '0;
    mdl_tag        = '0;
    mdl_machine_id = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_field_extremes();
    test_machine_id_extremes();
    test_chain_broken();
    test_random_traffic();

    // drain, then a few idle cycles to catch stray results
    settle_pipeline();
    if (mismatches == 0 && chain_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
